>>> rtl/core/pcam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcam_pkg
// Shared types, constants and register codes of the pair closest-approach
// monitor.
// ----------------------------------------------------------------------------
package pcam_pkg;

    // Fixed field widths
    localparam int SLOT_IN_W  = 6;   // pair_slot field on the input stream
    localparam int SLOT_CODES = 64;  // number of distinct pair_slot codes
    localparam int DIST_W     = 25;  // distance fields
    localparam int ROUND_W    = 26;  // round closest tracker, all ones = none
    localparam int CFG_W      = 24;  // configuration register width
    localparam int CFG_IDX_W  = 2;

    // Parameter defaults
    localparam int PAIR_SLOTS_DEF = 64;
    localparam int COORD_BITS_DEF = 24;

    // Register reset values, sixteenths of a metre
    localparam logic [CFG_W-1:0] IGNORE_RESET = CFG_W'(1600);
    localparam logic [CFG_W-1:0] REPORT_RESET = CFG_W'(800);
    localparam logic [CFG_W-1:0] SWING_RESET  = CFG_W'(16);

    localparam logic [ROUND_W-1:0] ROUND_NONE = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IGNORE = 2'd0,
        CFG_REPORT = 2'd1,
        CFG_SWING  = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_ROOT_GO,
        ST_ROOT,
        ST_WRITE
    } t_state;

    // Per-pair history word held in the pair memory
    typedef struct packed {
        logic [DIST_W-1:0] last_dist;
        logic              known;
        logic              closing;
        logic              valid;
        logic [DIST_W-1:0] run_min;
        logic [DIST_W-1:0] run_max;
    } t_entry;

    typedef struct packed {
        logic [CFG_W-1:0] ignore_lim;
        logic [CFG_W-1:0] report_lim;
        logic [CFG_W-1:0] swing_range;
    } t_cfg;

    typedef struct packed {
        logic              closing_out;
        logic              ev_flag;
        logic [DIST_W-1:0] ev_dist;
    } t_upd_res;

endpackage

>>> rtl/core/pcam_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcam_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pcam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/pcam_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcam_isqrt
// Bit-serial integer square root, floored; one result bit per cycle.
// ----------------------------------------------------------------------------
module pcam_isqrt #(
    parameter int ROOT_W = 25,
    localparam int RAD_W = 2 * ROOT_W - 1,
    localparam int REM_W = ROOT_W + 3,
    localparam int CNT_W = $clog2(ROOT_W + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RAD_W-1:0]  i_rad,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    logic [2*ROOT_W-1:0] r_rad;
    logic [REM_W-1:0]    r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [REM_W-1:0]    w_rem_sh;
    logic [REM_W-1:0]    w_trial;
    logic                w_ge;

    // Bring down the next two radicand bits and try root*4+1
    assign w_rem_sh = {r_rem[REM_W-3:0], r_rad[2*ROOT_W-1 -: 2]};
    assign w_trial  = REM_W'({r_root, 2'b01});
    assign w_ge     = (w_rem_sh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ROOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= {1'b0, i_rad};
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[2*ROOT_W-3:0], 2'b00};
            r_rem  <= w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
            r_root <= {r_root[ROOT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

>>> rtl/core/pcam_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcam_update
// Pair history update: ignore, first sighting, hysteresis and event check.
// ----------------------------------------------------------------------------
module pcam_update (
    input  pcam_pkg::t_entry                i_ent,
    input  logic [pcam_pkg::DIST_W-1:0]     i_dist,
    input  pcam_pkg::t_cfg                  i_cfg,
    output pcam_pkg::t_entry                o_ent,
    output pcam_pkg::t_upd_res              o_res
);

    localparam int DistW = pcam_pkg::DIST_W;

    logic [DistW-1:0] w_ignore;
    logic [DistW-1:0] w_report;
    logic [DistW-1:0] w_swing;

    assign w_ignore = DistW'(i_cfg.ignore_lim);
    assign w_report = DistW'(i_cfg.report_lim);
    assign w_swing  = DistW'(i_cfg.swing_range);

    always_comb begin
        o_ent = i_ent;
        if (i_dist > w_ignore) begin
            // Out of range: drop history flags, keep min and max
            o_ent.known   = 1'b0;
            o_ent.closing = 1'b0;
            o_ent.valid   = 1'b0;
        end else if (!i_ent.known) begin
            o_ent.last_dist = i_dist;
            o_ent.known     = 1'b1;
            o_ent.closing   = 1'b0;
            o_ent.valid     = 1'b0;
        end else if (i_ent.last_dist != i_dist) begin
            if (i_ent.last_dist > i_dist) begin
                if (!i_ent.closing && (i_ent.run_max > i_dist) &&
                    ((i_ent.run_max - i_dist) > w_swing)) begin
                    o_ent.closing = 1'b1;
                end
                o_ent.run_min = i_dist;
            end else begin
                if (i_ent.closing && (i_dist > i_ent.run_min) &&
                    ((i_dist - i_ent.run_min) > w_swing)) begin
                    o_ent.closing = 1'b0;
                end
                o_ent.run_max = i_dist;
            end
            o_ent.last_dist = i_dist;
            o_ent.valid     = 1'b1;
        end
    end

    always_comb begin
        o_res.closing_out = o_ent.closing;
        o_res.ev_flag     = i_ent.valid && o_ent.valid && i_ent.closing &&
                            !o_ent.closing && (o_ent.run_min <= w_report);
        o_res.ev_dist     = o_res.ev_flag ? o_ent.run_min : '0;
    end

endmodule

>>> rtl/core/pair_closest_approach_monitor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pair_closest_approach_monitor_unit
// Per-pair range tracker: distance, midpoint, round closest range and
// closing/opening hysteresis with closest-approach events.
// ----------------------------------------------------------------------------
//
// Channel       | Dir | Handshake                 | Payload
// --------------+-----+---------------------------+------------------------------
// s_axis        | in  | i_s_axis_tvalid/o_..ready | tdata: slot, own x/y,
//               |     |                           | contact x/y; tuser: round_start
// m_axis        | out | o_m_axis_tvalid/i_..ready | tdata: distance, closest,
//               |     |                           | closing, event, event dist, mid
// cfg           | in  | i_cfg_valid/o_cfg_ready   | i_cfg_index, i_cfg_data
//
// Steps: an observation passes through SQX, SQY, ROOT_GO, ROOT and WRITE;
// the bit-serial square root in ROOT yields one root bit per cycle.
// Reset: a clearing pass writes zero to every pair entry, one per cycle, with no
// observation taken; configuration is always ready.
// Stalls: a result waits in the output register while the next observation is
// worked on; the write-back stalls only while the previous result is untaken.
//
module pair_closest_approach_monitor_unit #(
    parameter int PAIR_SLOTS = pcam_pkg::PAIR_SLOTS_DEF,
    parameter int COORD_BITS = pcam_pkg::COORD_BITS_DEF,
    localparam int IN_BITS   = pcam_pkg::SLOT_IN_W + 4 * COORD_BITS,
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS  = 3 * pcam_pkg::DIST_W + 2 + 2 * COORD_BITS,
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Observation stream
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // tdata, low bit up: pair_slot, own_x, own_y, contact_x, contact_y, zero fill
    input  logic [IN_W-1:0]                i_s_axis_tdata,
    // tuser: round_start
    input  logic [0:0]                     i_s_axis_tuser,
    // Result stream
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // tdata, low bit up: distance, closest_in_round, closing mode, event_flag,
    // event_distance, mid_x, mid_y, zero fill
    output logic [OUT_W-1:0]               o_m_axis_tdata,
    // Configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pcam_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pcam_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int SlotW   = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;
    localparam int SlotInW = pcam_pkg::SLOT_IN_W;
    localparam int DistW   = pcam_pkg::DIST_W;
    localparam int RoundW  = pcam_pkg::ROUND_W;
    localparam int RootW   = COORD_BITS + 1;
    localparam int SqW     = 2 * COORD_BITS;
    localparam int EntW    = $bits(pcam_pkg::t_entry);

    // Input field offsets
    localparam int OffOx = SlotInW;
    localparam int OffOy = OffOx + COORD_BITS;
    localparam int OffCx = OffOy + COORD_BITS;
    localparam int OffCy = OffCx + COORD_BITS;

    // Output field offsets
    localparam int OffDist  = 0;
    localparam int OffClose = OffDist + DistW;
    localparam int OffMode  = OffClose + DistW;
    localparam int OffEv    = OffMode + 1;
    localparam int OffEvD   = OffEv + 1;
    localparam int OffMx    = OffEvD + DistW;
    localparam int OffMy    = OffMx + COORD_BITS;

    // ------------------------------------------------------------------
    // Slot code to memory row: code modulo PAIR_SLOTS, as a constant table
    // ------------------------------------------------------------------
    logic [SlotW-1:0] w_slot_map [pcam_pkg::SLOT_CODES];

    for (genvar g = 0; g < pcam_pkg::SLOT_CODES; g++) begin : g_slot_map
        localparam int SlotRow = g % PAIR_SLOTS;
        assign w_slot_map[g] = SlotW'(SlotRow);
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    pcam_pkg::t_cfg r_cfg;
    pcam_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                pcam_pkg::CFG_IGNORE: begin
                    // Keep report no greater than ignore
                    n_cfg.ignore_lim = i_cfg_data;
                    if (r_cfg.report_lim > i_cfg_data) begin
                        n_cfg.report_lim = i_cfg_data;
                    end
                end
                pcam_pkg::CFG_REPORT: begin
                    n_cfg.report_lim = i_cfg_data;
                    if (r_cfg.ignore_lim < i_cfg_data) begin
                        n_cfg.ignore_lim = i_cfg_data;
                    end
                end
                pcam_pkg::CFG_SWING: begin
                    n_cfg.swing_range = i_cfg_data;
                end
                default: begin
                    // Unknown index: drop the write
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ignore_lim  <= pcam_pkg::IGNORE_RESET;
            r_cfg.report_lim  <= pcam_pkg::REPORT_RESET;
            r_cfg.swing_range <= pcam_pkg::SWING_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // ------------------------------------------------------------------
    // Input decode: differences and midpoints taken at the transfer
    // ------------------------------------------------------------------
    logic [COORD_BITS-1:0] w_ox, w_oy, w_cx, w_cy;
    logic [COORD_BITS:0]   w_dx_s, w_dy_s, w_sx, w_sy;
    logic [COORD_BITS-1:0] w_dx_abs, w_dy_abs;
    logic [SlotW-1:0]      w_slot_in;

    assign w_ox = i_s_axis_tdata[OffOx +: COORD_BITS];
    assign w_oy = i_s_axis_tdata[OffOy +: COORD_BITS];
    assign w_cx = i_s_axis_tdata[OffCx +: COORD_BITS];
    assign w_cy = i_s_axis_tdata[OffCy +: COORD_BITS];

    assign w_dx_s = {w_ox[COORD_BITS-1], w_ox} - {w_cx[COORD_BITS-1], w_cx};
    assign w_dy_s = {w_oy[COORD_BITS-1], w_oy} - {w_cy[COORD_BITS-1], w_cy};
    assign w_sx   = {w_ox[COORD_BITS-1], w_ox} + {w_cx[COORD_BITS-1], w_cx};
    assign w_sy   = {w_oy[COORD_BITS-1], w_oy} + {w_cy[COORD_BITS-1], w_cy};

    // Magnitude of a difference always fits COORD_BITS
    assign w_dx_abs = w_dx_s[COORD_BITS] ? COORD_BITS'(-w_dx_s) : w_dx_s[COORD_BITS-1:0];
    assign w_dy_abs = w_dy_s[COORD_BITS] ? COORD_BITS'(-w_dy_s) : w_dy_s[COORD_BITS-1:0];

    assign w_slot_in = w_slot_map[i_s_axis_tdata[SlotInW-1:0]];

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    pcam_pkg::t_state r_state;
    pcam_pkg::t_state n_state;

    logic             w_accept;
    logic             w_out_free;
    logic             w_commit;
    logic             w_clear_we;
    logic             w_root_go;
    logic             w_sqrt_done;
    logic [RootW-1:0] w_root;

    logic [SlotW-1:0] r_clr_addr;

    assign w_out_free = !o_m_axis_tvalid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcam_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        w_accept        = 1'b0;
        w_commit        = 1'b0;
        w_clear_we      = 1'b0;
        w_root_go       = 1'b0;
        case (r_state)
            pcam_pkg::ST_CLEAR: begin
                w_clear_we = 1'b1;
                if (r_clr_addr == SlotW'(PAIR_SLOTS - 1)) begin
                    n_state = pcam_pkg::ST_IDLE;
                end
            end
            pcam_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                w_accept        = i_s_axis_tvalid;
                if (i_s_axis_tvalid) begin
                    n_state = pcam_pkg::ST_SQX;
                end
            end
            pcam_pkg::ST_SQX: begin
                n_state = pcam_pkg::ST_SQY;
            end
            pcam_pkg::ST_SQY: begin
                n_state = pcam_pkg::ST_ROOT_GO;
            end
            pcam_pkg::ST_ROOT_GO: begin
                w_root_go = 1'b1;
                n_state   = pcam_pkg::ST_ROOT;
            end
            pcam_pkg::ST_ROOT: begin
                if (w_sqrt_done) begin
                    n_state = pcam_pkg::ST_WRITE;
                end
            end
            pcam_pkg::ST_WRITE: begin
                // Hold until the output register can take the result
                if (w_out_free) begin
                    w_commit = 1'b1;
                    n_state  = pcam_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pcam_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (w_clear_we) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Observation datapath
    // ------------------------------------------------------------------
    logic [SlotW-1:0]      r_slot;
    logic                  r_round_start;
    logic [COORD_BITS-1:0] r_dx, r_dy;
    logic [COORD_BITS-1:0] r_mid_x, r_mid_y;
    logic [SqW-1:0]        r_sqx, r_sqy;
    pcam_pkg::t_entry      r_ent;
    logic [EntW-1:0]       w_rdata;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_slot        <= w_slot_in;
            r_round_start <= i_s_axis_tuser[0];
            r_dx          <= w_dx_abs;
            r_dy          <= w_dy_abs;
            // Floor of the half sum is the arithmetic shift right by one
            r_mid_x       <= w_sx[COORD_BITS:1];
            r_mid_y       <= w_sy[COORD_BITS:1];
        end
        if (r_state == pcam_pkg::ST_SQX) begin
            // Pair row read was issued at the transfer
            r_ent <= pcam_pkg::t_entry'(w_rdata);
            r_sqx <= r_dx * r_dx;
        end
        if (r_state == pcam_pkg::ST_SQY) begin
            r_sqy <= r_dy * r_dy;
        end
    end

    pcam_isqrt #(
        .ROOT_W (RootW)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_go),
        .i_rad   ({1'b0, r_sqx} + {1'b0, r_sqy}),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    // ------------------------------------------------------------------
    // Pair memory: read at the transfer, written back at commit
    // ------------------------------------------------------------------
    logic [DistW-1:0]     w_dist;
    pcam_pkg::t_entry     w_new_ent;
    pcam_pkg::t_upd_res   w_res;
    logic                 w_we;
    logic [SlotW-1:0]     w_waddr;
    logic [EntW-1:0]      w_wdata;

    assign w_dist = DistW'(w_root);

    pcam_update u_update (
        .i_ent  (r_ent),
        .i_dist (w_dist),
        .i_cfg  (r_cfg),
        .o_ent  (w_new_ent),
        .o_res  (w_res)
    );

    assign w_we    = w_clear_we || w_commit;
    assign w_waddr = w_clear_we ? r_clr_addr : r_slot;
    assign w_wdata = w_clear_we ? '0 : EntW'(w_new_ent);

    pcam_ram #(
        .WIDTH (EntW),
        .DEPTH (PAIR_SLOTS)
    ) u_pair_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_slot_in),
        .o_rdata (w_rdata)
    );

    // ------------------------------------------------------------------
    // Round closest tracker
    // ------------------------------------------------------------------
    logic [RoundW-1:0] r_round_closest;
    logic [RoundW-1:0] w_round_base;
    logic [RoundW-1:0] n_round_closest;

    always_comb begin
        w_round_base    = r_round_start ? pcam_pkg::ROUND_NONE : r_round_closest;
        n_round_closest = w_round_base;
        if ((w_round_base == pcam_pkg::ROUND_NONE) ||
            (RoundW'(w_dist) < w_round_base)) begin
            n_round_closest = RoundW'(w_dist);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round_closest <= pcam_pkg::ROUND_NONE;
        end else if (w_commit) begin
            r_round_closest <= n_round_closest;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    logic [OUT_W-1:0] n_out_data;

    always_comb begin
        n_out_data                          = '0;
        n_out_data[OffDist +: DistW]        = w_dist;
        n_out_data[OffClose +: DistW]       = n_round_closest[DistW-1:0];
        n_out_data[OffMode]                 = w_res.closing_out;
        n_out_data[OffEv]                   = w_res.ev_flag;
        n_out_data[OffEvD +: DistW]         = w_res.ev_dist;
        n_out_data[OffMx +: COORD_BITS]     = r_mid_x;
        n_out_data[OffMy +: COORD_BITS]     = r_mid_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the pair closest-approach monitor against an in-bench tracker of
// pair range, round closest range, hysteresis and closest-approach events.
// A directed opening is followed by random approach passes and noise, under
// several register settings. Sender bursts and receiver stalls are random,
// and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module testbench;

    localparam int COORD     = pcam_pkg::COORD_BITS_DEF;
    localparam int PAIRS     = pcam_pkg::PAIR_SLOTS_DEF;
    localparam int SLOT_W    = pcam_pkg::SLOT_IN_W;
    localparam int DIST_W    = pcam_pkg::DIST_W;
    localparam int CFG_W     = pcam_pkg::CFG_W;
    localparam int CFG_IDX_W = pcam_pkg::CFG_IDX_W;
    localparam int ROUND_W   = pcam_pkg::ROUND_W;
    localparam int IN_W      = ((SLOT_W + 4 * COORD + 7) / 8) * 8;
    localparam int OUT_W     = ((3 * DIST_W + 2 + 2 * COORD + 7) / 8) * 8;
    localparam int COORD_MAX = 2 ** (COORD - 1) - 1;
    localparam int COORD_MIN = -(2 ** (COORD - 1));

    // Result fields, low bit up
    localparam int OFS_DIST    = 0;
    localparam int OFS_CLOSEST = OFS_DIST + DIST_W;
    localparam int OFS_CLOSING = OFS_CLOSEST + DIST_W;
    localparam int OFS_EVENT   = OFS_CLOSING + 1;
    localparam int OFS_EVDIST  = OFS_EVENT + 1;
    localparam int OFS_MIDX    = OFS_EVDIST + DIST_W;
    localparam int OFS_MIDY    = OFS_MIDX + COORD;

    // Index with no register behind it; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int PASSES       = 4;    // approach passes in flight at once
    localparam int HOLD_CYCLES  = 400;  // long receiver hold-off
    localparam int DRAIN_CYCLES = 48;   // longer than one observation
    localparam int SETTLE_LIMIT = 200000;

    typedef struct {
        logic [SLOT_W-1:0]       slot;
        logic                    round_start;
        logic signed [COORD-1:0] own_x;
        logic signed [COORD-1:0] own_y;
        logic signed [COORD-1:0] contact_x;
        logic signed [COORD-1:0] contact_y;
    } t_obs;

    typedef struct {
        logic [DIST_W-1:0]       distance;
        logic [DIST_W-1:0]       closest;
        logic                    closing;
        logic                    ev_flag;
        logic [DIST_W-1:0]       ev_dist;
        logic signed [COORD-1:0] mid_x;
        logic signed [COORD-1:0] mid_y;
    } t_range_report;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_CHOPPY,
        RX_SPARSE
    } t_rx_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    // tdata, low bit up: pair_slot, own_x, own_y, contact_x, contact_y, zero fill
    logic [IN_W-1:0]      i_s_axis_tdata = '0;
    // tuser: round_start
    logic [0:0]           i_s_axis_tuser = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    // tdata, low bit up: distance, closest_in_round, closing mode, event_flag,
    // event_distance, mid_x, mid_y, zero fill
    logic [OUT_W-1:0]     o_m_axis_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    // Tracker copy of the registers and of the per-pair history
    logic [CFG_W-1:0]   cfg_ignore = pcam_pkg::IGNORE_RESET;
    logic [CFG_W-1:0]   cfg_report = pcam_pkg::REPORT_RESET;
    logic [CFG_W-1:0]   cfg_swing  = pcam_pkg::SWING_RESET;
    logic [DIST_W-1:0]  seen_dist    [PAIRS] = '{default: '0};
    logic               dist_known   [PAIRS] = '{default: 1'b0};
    logic               closing_now  [PAIRS] = '{default: 1'b0};
    logic               pair_ok      [PAIRS] = '{default: 1'b0};
    logic [DIST_W-1:0]  low_water    [PAIRS] = '{default: '0};
    logic [DIST_W-1:0]  high_water   [PAIRS] = '{default: '0};
    logic [ROUND_W-1:0] round_best = pcam_pkg::ROUND_NONE;

    t_obs          obs_backlog [$];
    t_range_report report_due [$];
    t_obs          on_bus;
    logic          obs_taken = 1'b0;
    int unsigned   mismatch_count = 0;
    int unsigned   hold_request = 0;

    always #1 i_clk = ~i_clk;

    pair_closest_approach_monitor_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Range tracker
    // ------------------------------------------------------------------------

    // Bit-pair restoring square root, floored
    function automatic longint unsigned floor_root(longint unsigned n);
        longint unsigned root;
        longint unsigned bit_w;
        root  = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > n) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (n >= root + bit_w) begin
                n    = n - (root + bit_w);
                root = (root >> 1) + bit_w;
            end else begin
                root = root >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return root;
    endfunction

    // Advance the pair history by one observation and return its report
    function automatic t_range_report track_pair(t_obs o);
        int unsigned   s;
        longint        dx;
        longint        dy;
        longint        mx;
        longint        my;
        logic [DIST_W-1:0] d;
        logic          was_closing;
        logic          was_ok;
        t_range_report r;
        s  = o.slot % PAIRS;
        dx = longint'(o.own_x) - longint'(o.contact_x);
        dy = longint'(o.own_y) - longint'(o.contact_y);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        d  = DIST_W'(floor_root(longint'(dx * dx + dy * dy)));
        was_closing = closing_now[s];
        was_ok      = pair_ok[s];

        if (o.round_start) round_best = pcam_pkg::ROUND_NONE;
        if (round_best == pcam_pkg::ROUND_NONE || {1'b0, d} < round_best)
            round_best = {1'b0, d};

        if (d > cfg_ignore) begin
            // Out of range: forget the pair but keep its extremes
            dist_known[s]  = 1'b0;
            closing_now[s] = 1'b0;
            pair_ok[s]     = 1'b0;
        end else if (!dist_known[s]) begin
            seen_dist[s]   = d;
            dist_known[s]  = 1'b1;
            closing_now[s] = 1'b0;
            pair_ok[s]     = 1'b0;
        end else if (seen_dist[s] != d) begin
            if (seen_dist[s] > d) begin
                if (!was_closing && high_water[s] > d && high_water[s] - d > cfg_swing)
                    closing_now[s] = 1'b1;
                low_water[s] = d;
            end else begin
                if (was_closing && d > low_water[s] && d - low_water[s] > cfg_swing)
                    closing_now[s] = 1'b0;
                high_water[s] = d;
            end
            seen_dist[s] = d;
            pair_ok[s]   = 1'b1;
        end

        r.distance = d;
        r.closest  = round_best[DIST_W-1:0];
        r.closing  = closing_now[s];
        r.ev_flag  = was_ok && pair_ok[s] && was_closing && !closing_now[s] &&
                     low_water[s] <= cfg_report;
        r.ev_dist  = r.ev_flag ? low_water[s] : '0;
        mx = (longint'(o.own_x) + longint'(o.contact_x)) >>> 1;
        my = (longint'(o.own_y) + longint'(o.contact_y)) >>> 1;
        r.mid_x = mx[COORD-1:0];
        r.mid_y = my[COORD-1:0];
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // Observation driver: bursts of random length, random gaps between them
    // ------------------------------------------------------------------------
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;

    always @(negedge i_clk) begin
        t_obs o;
        if (i_rst_n && (!i_s_axis_tvalid || obs_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_s_axis_tvalid <= 1'b0;
            end else if (obs_backlog.size() != 0) begin
                o      = obs_backlog.pop_front();
                on_bus = o;
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tuser  <= o.round_start;
                i_s_axis_tdata  <= IN_W'({o.contact_y, o.contact_x, o.own_y, o.own_x,
                                          o.slot});
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 8);
                    // A quarter of bursts run straight into the next one
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
                end else begin
                    burst_left--;
                end
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: stall pattern in stretches, plus a long hold-off
    // ------------------------------------------------------------------------
    t_rx_mode    rx_mode = RX_STEADY;
    int unsigned rx_left = 0;
    int unsigned hold_left = 0;
    int unsigned hold_seen = 0;

    always @(negedge i_clk) begin
        logic ready;
        if (hold_seen != hold_request) begin
            hold_seen = hold_request;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            // Hold off so the result register fills and the input backs up
            hold_left--;
            ready = 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 2));
                rx_left = $urandom_range(20, 200);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                RX_STEADY: ready = 1'b1;
                RX_CHOPPY: ready = 1'($urandom_range(0, 1));
                default:   ready = ($urandom_range(0, 3) == 0);
            endcase
        end
        i_m_axis_tready <= ready;
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on each input transfer, check each output transfer
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_range_report want;
        t_range_report got;
        obs_taken = i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (obs_taken) report_due.insert(report_due.size(), track_pair(on_bus));

        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.distance = o_m_axis_tdata[OFS_DIST +: DIST_W];
            got.closest  = o_m_axis_tdata[OFS_CLOSEST +: DIST_W];
            got.closing  = o_m_axis_tdata[OFS_CLOSING];
            got.ev_flag  = o_m_axis_tdata[OFS_EVENT];
            got.ev_dist  = o_m_axis_tdata[OFS_EVDIST +: DIST_W];
            got.mid_x    = o_m_axis_tdata[OFS_MIDX +: COORD];
            got.mid_y    = o_m_axis_tdata[OFS_MIDY +: COORD];
            if (report_due.size() == 0) begin
                mismatch_count++;
                $display("%0t ns: result transfer with none expected, tdata %0h",
                         $time, o_m_axis_tdata);
            end else begin
                want = report_due.pop_front();
                check_field("distance", want.distance, got.distance);
                check_field("closest_in_round", want.closest, got.closest);
                check_field("closing mode", want.closing, got.closing);
                check_field("event_flag", want.ev_flag, got.ev_flag);
                check_field("event_distance", want.ev_dist, got.ev_dist);
                check_field("mid_x", want.mid_x, got.mid_x);
                check_field("mid_y", want.mid_y, got.mid_y);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic add_obs(int slot, bit rs, int ox, int oy, int cx, int cy);
        t_obs o;
        o.slot        = SLOT_W'(slot);
        o.round_start = rs;
        o.own_x       = COORD'(ox);
        o.own_y       = COORD'(oy);
        o.contact_x   = COORD'(cx);
        o.contact_y   = COORD'(cy);
        obs_backlog.insert(obs_backlog.size(), o);
    endtask

    // Register write; the tracker copy follows the same clamping rules
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            pcam_pkg::CFG_IGNORE: begin
                cfg_ignore = value;
                if (cfg_report > cfg_ignore) cfg_report = cfg_ignore;
            end
            pcam_pkg::CFG_REPORT: begin
                cfg_report = value;
                if (cfg_ignore < cfg_report) cfg_ignore = cfg_report;
            end
            pcam_pkg::CFG_SWING: cfg_swing = value;
            default: ;
        endcase
    endtask

    task automatic close_cfg();
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every item is in and every result is out, then let it drain
    task automatic settle();
        int unsigned waited;
        waited = 0;
        while ((obs_backlog.size() != 0 || i_s_axis_tvalid || report_due.size() != 0) &&
               waited < SETTLE_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Approach passes: each pass climbs away for two steps, then sweeps its
    // contact past the own vehicle at a random miss distance, so the range
    // opens, closes and opens again. A few passes share the stream at once,
    // with noise items mixed in.
    task automatic run_traffic(int unsigned n_items, int unsigned reach);
        int unsigned made;
        int          p;
        bit          live   [PASSES];
        int          along  [PASSES];
        int          climb  [PASSES];
        int          stride [PASSES];
        int          miss   [PASSES];
        int          stop_at[PASSES];
        int          base_x [PASSES];
        int          base_y [PASSES];
        bit          swap   [PASSES];
        int          sign_a [PASSES];
        int          sign_m [PASSES];
        int          slot_of[PASSES];
        int          ax;
        int          ay;
        bit          rs;
        live = '{default: 1'b0};
        for (made = 0; made < n_items; made++) begin
            rs = ($urandom_range(0, 32) == 0);
            if ($urandom_range(0, 7) == 0) begin
                add_obs($urandom_range(0, PAIRS - 1), rs, $urandom(), $urandom(),
                        $urandom(), $urandom());
            end else begin
                p = $urandom_range(0, PASSES - 1);
                if (!live[p]) begin
                    live[p]    = 1'b1;
                    slot_of[p] = $urandom_range(0, PAIRS - 1);
                    stride[p]  = reach / $urandom_range(6, 20) + $urandom_range(1, 3);
                    along[p]   = $urandom_range(reach / 2, reach);
                    stop_at[p] = -along[p];
                    climb[p]   = 2;
                    miss[p]    = $urandom_range(0, reach);
                    base_x[p]  = int'($urandom_range(0, COORD_MAX)) + COORD_MIN / 2;
                    base_y[p]  = int'($urandom_range(0, COORD_MAX)) + COORD_MIN / 2;
                    swap[p]    = 1'($urandom_range(0, 1));
                    sign_a[p]  = $urandom_range(0, 1) ? 1 : -1;
                    sign_m[p]  = $urandom_range(0, 1) ? 1 : -1;
                end
                ax = swap[p] ? sign_m[p] * miss[p] : sign_a[p] * along[p];
                ay = swap[p] ? sign_a[p] * along[p] : sign_m[p] * miss[p];
                add_obs(slot_of[p], rs, base_x[p], base_y[p], base_x[p] + ax, base_y[p] + ay);
                if (climb[p] > 0) begin
                    along[p] += stride[p];
                    climb[p]--;
                end else begin
                    along[p] -= stride[p];
                end
                if (along[p] < stop_at[p]) live[p] = 1'b0;
            end
        end
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Register reset values: 1600 ignore, 800 report, 16 swing
        add_obs(0, 1, 0, 0, 0, 0);                           // round start, first sighting
        add_obs(63, 0, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);  // widest span
        add_obs(62, 0, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
        add_obs(61, 0, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);  // zero range
        add_obs(5, 0, -3, 0, 0, 0);                          // odd negative midpoint
        add_obs(5, 0, -3, 0, 0, 0);                          // range unchanged
        add_obs(5, 0, 0, 0, 100, 0);                         // opening, sets high water
        add_obs(5, 0, 0, 0, 0, 50);                          // swings to closing
        add_obs(5, 0, 0, 0, 40, 0);
        add_obs(5, 0, 0, 0, -30, -40);                       // small rise, still closing
        add_obs(5, 0, 0, 0, 56, 0);                          // rise equal to swing
        add_obs(5, 0, 0, 0, 57, 0);                          // flips open: event
        add_obs(5, 0, 0, 0, 1600, 0);                        // right on the ignore range
        add_obs(5, 0, 0, 0, 1601, 0);                        // just beyond it
        add_obs(5, 0, 1, 1, 2, 2);                           // history starts again
        add_obs(5, 1, 7, -9, 7, -9);
        add_obs(6, 0, 0, 0, 1000, 0);                        // minimum on the report range
        add_obs(6, 0, 0, 0, 0, 1200);
        add_obs(6, 0, 0, 0, 800, 0);
        add_obs(6, 0, 0, 0, 0, 900);
        add_obs(8, 0, 0, 0, 0, 1000);                        // minimum just above it
        add_obs(8, 0, 0, 0, 1200, 0);
        add_obs(8, 0, 0, 0, 0, 801);
        add_obs(8, 0, 0, 0, 900, 0);
        run_traffic(300, 1200);
        settle();

        // Everything in range, no hysteresis
        write_reg(pcam_pkg::CFG_IGNORE, '1);
        write_reg(pcam_pkg::CFG_REPORT, '1);
        write_reg(pcam_pkg::CFG_SWING, '0);
        close_cfg();
        run_traffic(300, 2000000);
        settle();

        // Ignore everything but zero range; report follows down
        write_reg(pcam_pkg::CFG_SWING, CFG_W'(5));
        write_reg(pcam_pkg::CFG_IGNORE, '0);
        write_reg(CFG_SPARE, CFG_W'($urandom()));
        close_cfg();
        run_traffic(150, 30);
        settle();

        // Report raises ignore; a swing no change can exceed
        write_reg(pcam_pkg::CFG_REPORT, CFG_W'(3000));
        write_reg(pcam_pkg::CFG_SWING, '1);
        close_cfg();
        run_traffic(150, 2500);
        settle();

        // Mid settings, with the receiver holding off at the start
        write_reg(pcam_pkg::CFG_IGNORE, CFG_W'(5000));
        write_reg(pcam_pkg::CFG_REPORT, CFG_W'(2500));
        write_reg(pcam_pkg::CFG_SWING, CFG_W'(40));
        close_cfg();
        hold_request++;
        run_traffic(400, 4000);
        settle();

        // Back to the reset values; ignore first so report is clamped
        write_reg(pcam_pkg::CFG_IGNORE, pcam_pkg::IGNORE_RESET);
        write_reg(pcam_pkg::CFG_REPORT, pcam_pkg::REPORT_RESET);
        write_reg(pcam_pkg::CFG_SWING, pcam_pkg::SWING_RESET);
        close_cfg();
        run_traffic(500, 1200);
        settle();

        if (mismatch_count == 0 && report_due.size() == 0) begin
            $display("[pair_closest_approach_monitor_unit] OK");
        end else begin
            if (report_due.size() != 0)
                $display("%0t ns: %0d results never arrived", $time, report_due.size());
            $display("[pair_closest_approach_monitor_unit] ERROR");
        end
        $finish;
    end

    // Run limit, well beyond the slowest correct run
    initial begin
        #3000000;
        $display("%0t ns: run limit reached", $time);
        $display("[pair_closest_approach_monitor_unit] ERROR");
        $finish;
    end

endmodule
